>>> design/rxs_pkg.sv
`timescale 1ns / 1ps

package rxs_pkg;

  localparam int DEPTH_DEF    = 64;
  localparam int KEY_BITS_DEF = 32;
  localparam int PRICE_W      = 32;
  localparam int TAG_W        = 6;

endpackage

>>> design/rxs_ram.sv
`timescale 1ns / 1ps

module rxs_ram #(
  parameter int WIDTH  = 38,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = 6
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> design/record_exchange_sorter.sv
`timescale 1ns / 1ps

// Collects a set of records (key + tag) into an on-chip RAM until an item with
// in_last arrives, then sorts the set in place by exchange sort and streams it
// out, the final item flagged by out_last_out. Items past DEPTH are dropped and
// out_overflow is set on every result of that set. The direction is taken from
// the cfg register when the closing item arrives. Input is stalled from the
// closing item until the last result is taken. Loading takes one item per
// cycle; the sort makes one RAM read-compare-write per cycle, row by row,
// bounded by the single RAM read port; output holds one result at a time and
// registers the next one only after the previous one is taken.
module record_exchange_sorter #(
  parameter int DEPTH    = rxs_pkg::DEPTH_DEF,
  parameter int KEY_BITS = rxs_pkg::KEY_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [rxs_pkg::PRICE_W-1:0] in_price_cents,
  input  logic [rxs_pkg::TAG_W-1:0]  in_record_tag,
  input  logic                       in_last,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [rxs_pkg::PRICE_W-1:0] out_sorted_price,
  output logic [rxs_pkg::TAG_W-1:0]  out_sorted_tag,
  output logic                       out_last_out,
  output logic                       out_overflow,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic                       cfg_sort_descending
);

  import rxs_pkg::*;

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int REC_W = KEY_BITS + TAG_W;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_ROW,
    ST_HEAD,
    ST_SCAN,
    ST_ROWEND,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_EMIT_WAIT
  } state_t;

  state_t               state_r;
  logic [CNT_W-1:0]     count_r;
  logic                 dropped_r;
  logic                 desc_cfg_r;
  logic                 desc_r;
  logic [IDX_W-1:0]     last_r;
  logic [IDX_W-1:0]     i_r;
  logic [IDX_W-1:0]     j_r;
  logic [IDX_W-1:0]     jd_r;
  logic [IDX_W-1:0]     k_r;
  logic [REC_W-1:0]     cur_r;
  logic                 out_valid_r;
  logic [PRICE_W-1:0]   out_price_r;
  logic [TAG_W-1:0]     out_tag_r;
  logic                 out_last_r;
  logic                 out_ovf_r;

  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic [REC_W-1:0]     ram_wdata;
  logic [IDX_W-1:0]     ram_raddr;
  logic [REC_W-1:0]     ram_rdata;

  logic                 in_fire;
  logic                 out_fire;
  logic                 has_room;
  logic [CNT_W-1:0]     n_nxt;
  logic [KEY_BITS-1:0]  key_in;
  logic [KEY_BITS-1:0]  rd_key;
  logic [KEY_BITS-1:0]  cur_key;
  logic                 better;

  assign in_stall  = (state_r != ST_LOAD);
  assign in_fire   = in_valid && !in_stall;
  assign out_fire  = out_valid_r && !out_stall;
  assign cfg_ready = 1'b1;

  assign has_room = (count_r < CNT_W'(DEPTH));
  assign n_nxt    = has_room ? count_r + 1'b1 : count_r;
  assign key_in   = KEY_BITS'(in_price_cents);
  assign rd_key   = ram_rdata[TAG_W +: KEY_BITS];
  assign cur_key  = cur_r[TAG_W +: KEY_BITS];
  assign better   = desc_r ? (rd_key > cur_key) : (rd_key < cur_key);

  assign out_valid        = out_valid_r;
  assign out_sorted_price = out_price_r;
  assign out_sorted_tag   = out_tag_r;
  assign out_last_out     = out_last_r;
  assign out_overflow     = out_ovf_r;

  rxs_ram #(
    .WIDTH  (REC_W),
    .DEPTH  (DEPTH),
    .ADDR_W (IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // RAM port steering; entry i lives in cur_r for the whole row
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = i_r;
    ram_wdata = cur_r;
    ram_raddr = i_r;
    unique case (state_r)
      ST_LOAD: begin
        ram_we    = in_fire && has_room;
        ram_waddr = count_r[IDX_W-1:0];
        ram_wdata = {key_in, in_record_tag};
      end
      ST_ROW: begin
        ram_raddr = i_r;
      end
      ST_HEAD: begin
        ram_raddr = j_r;
      end
      ST_SCAN: begin
        ram_we    = better;
        ram_waddr = jd_r;
        ram_raddr = j_r;
      end
      ST_ROWEND: begin
        ram_we    = 1'b1;
        ram_waddr = i_r;
        ram_raddr = i_r + 1'b1;
      end
      ST_EMIT_RD: begin
        ram_raddr = k_r;
      end
      ST_EMIT_LD: begin
        ram_raddr = k_r;
      end
      ST_EMIT_WAIT: begin
        ram_raddr = k_r + 1'b1;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      desc_cfg_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      desc_cfg_r <= cfg_sort_descending;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      count_r     <= '0;
      dropped_r   <= 1'b0;
      out_valid_r <= 1'b0;
      desc_r      <= 1'b0;
      i_r         <= '0;
      j_r         <= '0;
      jd_r        <= '0;
      k_r         <= '0;
      last_r      <= '0;
    end else begin
      unique case (state_r)
        ST_LOAD: begin
          if (in_fire) begin
            if (has_room) begin
              count_r <= count_r + 1'b1;
            end else begin
              dropped_r <= 1'b1;
            end
            if (in_last) begin
              desc_r <= desc_cfg_r;
              last_r <= IDX_W'(n_nxt - 1'b1);
              j_r    <= IDX_W'(n_nxt - 1'b1);
              i_r    <= '0;
              k_r    <= '0;
              if (n_nxt <= CNT_W'(1)) begin
                state_r <= ST_EMIT_RD;
              end else begin
                state_r <= ST_ROW;
              end
            end
          end
        end
        ST_ROW: begin
          state_r <= ST_HEAD;
        end
        ST_HEAD: begin
          cur_r   <= ram_rdata;
          jd_r    <= j_r;
          j_r     <= j_r - 1'b1;
          state_r <= ST_SCAN;
        end
        ST_SCAN: begin
          if (better) begin
            cur_r <= ram_rdata;
          end
          if (jd_r == i_r + 1'b1) begin
            state_r <= ST_ROWEND;
          end else begin
            jd_r <= j_r;
            j_r  <= j_r - 1'b1;
          end
        end
        ST_ROWEND: begin
          i_r <= i_r + 1'b1;
          j_r <= last_r;
          if (i_r + 1'b1 == last_r) begin
            state_r <= ST_EMIT_RD;
          end else begin
            state_r <= ST_HEAD;
          end
        end
        ST_EMIT_RD: begin
          state_r <= ST_EMIT_LD;
        end
        ST_EMIT_LD: begin
          out_price_r <= PRICE_W'(rd_key);
          out_tag_r   <= ram_rdata[TAG_W-1:0];
          out_last_r  <= (k_r == last_r);
          out_ovf_r   <= dropped_r;
          out_valid_r <= 1'b1;
          state_r     <= ST_EMIT_WAIT;
        end
        ST_EMIT_WAIT: begin
          if (out_fire) begin
            out_valid_r <= 1'b0;
            if (out_last_r) begin
              count_r   <= '0;
              dropped_r <= 1'b0;
              state_r   <= ST_LOAD;
            end else begin
              k_r     <= k_r + 1'b1;
              state_r <= ST_EMIT_LD;
            end
          end
        end
        default: begin
          state_r <= ST_LOAD;
        end
      endcase
    end
  end

endmodule

>>> tb/record_exchange_sorter_test.sv
`timescale 1ns / 1ps

module record_exchange_sorter_test;

  localparam int DEPTH     = rxs_pkg::DEPTH_DEF;
  localparam int PRICE_W   = rxs_pkg::PRICE_W;
  localparam int TAG_W     = rxs_pkg::TAG_W;
  localparam int MAX_CYC   = 400000;
  localparam int N_DIRECT  = 20;
  localparam int PHASE_LEN = 110;

  typedef struct packed {
    logic [PRICE_W-1:0] price;
    logic [TAG_W-1:0]   tag;
    logic               last_out;
    logic               overflow;
  } sorted_rec_t;

  // typed = 1: the single result of this set is written out in the row
  typedef struct packed {
    logic [PRICE_W-1:0] price;
    logic [TAG_W-1:0]   tag;
    logic               last;
    logic               typed;
    sorted_rec_t        want;
  } stim_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [PRICE_W-1:0] in_price_cents = '0;
  logic [TAG_W-1:0]   in_record_tag = '0;
  logic               in_last = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [PRICE_W-1:0] out_sorted_price;
  logic [TAG_W-1:0]   out_sorted_tag;
  logic               out_last_out;
  logic               out_overflow;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic               cfg_sort_descending = 1'b0;

  // price-book model of the sorter
  logic [PRICE_W-1:0] book_price [DEPTH];
  logic [TAG_W-1:0]   book_tag [DEPTH];
  int                 book_count = 0;
  logic               book_dropped = 1'b0;
  logic               book_desc = 1'b0;

  sorted_rec_t        sorted_due [$];
  sorted_rec_t        seen_rec;
  sorted_rec_t        due_rec;
  int                 err_count = 0;

  stim_row_t          directed_tab [N_DIRECT];

  record_exchange_sorter i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_price_cents      (in_price_cents),
    .in_record_tag       (in_record_tag),
    .in_last             (in_last),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_sorted_price    (out_sorted_price),
    .out_sorted_tag      (out_sorted_tag),
    .out_last_out        (out_last_out),
    .out_overflow        (out_overflow),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_sort_descending (cfg_sort_descending)
  );

  always #4 clk = ~clk;

  // append one expected result at the tail of the queue
  function automatic void queue_due(input sorted_rec_t r);
    sorted_due.insert(sorted_due.size(), r);
  endfunction

  // Store one accepted record; on last, sort the book and queue the ordered set if enqueue is set.
  task automatic book_record(input logic [PRICE_W-1:0] price, input logic [TAG_W-1:0] tag,
                             input logic last, input bit enqueue);
    int i;
    int j;
    logic [PRICE_W-1:0] k;
    logic [TAG_W-1:0] t;
    logic better;
    sorted_rec_t r;
    if (book_count < DEPTH) begin
      book_price[book_count] = price;
      book_tag[book_count] = tag;
      book_count++;
    end else begin
      book_dropped = 1'b1;
    end
    if (last) begin
      for (i = 0; i < book_count; i++) begin
        for (j = book_count - 1; j > i; j--) begin
          better = book_desc ? (book_price[j] > book_price[i]) : (book_price[j] < book_price[i]);
          if (better) begin
            k = book_price[i];
            t = book_tag[i];
            book_price[i] = book_price[j];
            book_tag[i] = book_tag[j];
            book_price[j] = k;
            book_tag[j] = t;
          end
        end
      end
      for (i = 0; i < book_count; i++) begin
        r.price = book_price[i];
        r.tag = book_tag[i];
        r.last_out = (i == book_count - 1);
        r.overflow = book_dropped;
        if (enqueue) queue_due(r);
      end
      book_count = 0;
      book_dropped = 1'b0;
    end
  endtask

  // Valid stays high across back-to-back items; it only drops for a gap.
  task automatic push_record(input logic [PRICE_W-1:0] price, input logic [TAG_W-1:0] tag,
                             input logic last, input int gap, input bit typed,
                             input sorted_rec_t want);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_price_cents <= price;
    in_record_tag <= tag;
    in_last <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    book_record(price, tag, last, !typed);
    if (typed) queue_due(want);
  endtask

  task automatic write_direction(input logic desc);
    in_valid <= 1'b0;
    while (sorted_due.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_sort_descending <= desc;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    book_desc = desc;
  endtask

  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic logic [PRICE_W-1:0] rand_price(input bit tie_heavy);
    int r;
    r = $urandom_range(0, 9);
    if (tie_heavy) return $urandom_range(0, 3);
    case (r)
      0: return '0;
      1: return '1;
      2, 3: return $urandom_range(0, 7);
      4: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  function automatic int set_length();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return $urandom_range(1, 6);
    if (r < 9) return $urandom_range(7, 16);
    return $urandom_range(17, 40);
  endfunction

  task automatic note_mismatch(input string what, input sorted_rec_t want,
                               input sorted_rec_t got);
    err_count++;
    if (err_count <= 10)
      $display("%0t %s: exp price=%h tag=%0d last=%b ovf=%b, got price=%h tag=%0d last=%b ovf=%b",
               $realtime, what, want.price, want.tag, want.last_out, want.overflow,
               got.price, got.tag, got.last_out, got.overflow);
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      seen_rec.price = out_sorted_price;
      seen_rec.tag = out_sorted_tag;
      seen_rec.last_out = out_last_out;
      seen_rec.overflow = out_overflow;
      if (sorted_due.size() == 0) begin
        note_mismatch("unexpected item", '0, seen_rec);
      end else begin
        due_rec = sorted_due.pop_front();
        if (seen_rec !== due_rec) note_mismatch("mismatch", due_rec, seen_rec);
      end
    end
  end

  // receiver backpressure: mostly short runs, a few long stalls, some free stretches
  initial begin
    int r;
    int len;
    forever begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        out_stall <= 1'b0;
        len = $urandom_range(1, 6);
      end else if (r < 85) begin
        out_stall <= 1'b1;
        len = $urandom_range(1, 3);
      end else if (r < 95) begin
        out_stall <= 1'b1;
        len = $urandom_range(8, 40);
      end else begin
        out_stall <= 1'b0;
        len = $urandom_range(50, 200);
      end
      repeat (len) @(posedge clk);
    end
  end

  initial begin
    repeat (MAX_CYC) @(posedge clk);
    $display("record_exchange_sorter regression: fail");
    $finish;
  end

  initial begin
    int ph;
    int n;
    int k;
    int phase_items;
    bit burst;
    bit tie_heavy;
    directed_tab = '{
      // single-record sets: result equals the record
      '{32'hFFFF_FFFF, 6'd63, 1'b1, 1'b1, '{32'hFFFF_FFFF, 6'd63, 1'b1, 1'b0}},
      '{32'h0000_0000, 6'd0,  1'b1, 1'b1, '{32'h0000_0000, 6'd0,  1'b1, 1'b0}},
      // ties: order of equal keys follows the swap sequence
      '{32'd5, 6'd1, 1'b0, 1'b0, '0},
      '{32'd3, 6'd2, 1'b0, 1'b0, '0},
      '{32'd5, 6'd3, 1'b0, 1'b0, '0},
      '{32'd3, 6'd4, 1'b0, 1'b0, '0},
      '{32'd0, 6'd5, 1'b1, 1'b0, '0},
      // key extremes and the sign-bit boundary
      '{32'h8000_0000, 6'd10, 1'b0, 1'b0, '0},
      '{32'hFFFF_FFFF, 6'd11, 1'b0, 1'b0, '0},
      '{32'h7FFF_FFFF, 6'd12, 1'b0, 1'b0, '0},
      '{32'h0000_0001, 6'd13, 1'b1, 1'b0, '0},
      // all keys equal
      '{32'd7, 6'd20, 1'b0, 1'b0, '0},
      '{32'd7, 6'd21, 1'b0, 1'b0, '0},
      '{32'd7, 6'd22, 1'b1, 1'b0, '0},
      // reverse-ordered input
      '{32'd9, 6'd30, 1'b0, 1'b0, '0},
      '{32'd8, 6'd31, 1'b0, 1'b0, '0},
      '{32'd7, 6'd32, 1'b0, 1'b0, '0},
      '{32'd6, 6'd33, 1'b1, 1'b0, '0},
      // two max keys, tag extremes
      '{32'hFFFF_FFFF, 6'd63, 1'b0, 1'b0, '0},
      '{32'hFFFF_FFFF, 6'd0,  1'b1, 1'b0, '0}
    };

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part runs in the reset direction (ascending)
    for (k = 0; k < N_DIRECT; k++)
      push_record(directed_tab[k].price, directed_tab[k].tag, directed_tab[k].last,
                  idle_gap(), directed_tab[k].typed, directed_tab[k].want);

    // random phases alternate direction; each opens with a full or overflowing set
    for (ph = 0; ph < 4; ph++) begin
      write_direction(ph % 2 == 0);
      phase_items = 0;
      while (phase_items < PHASE_LEN) begin
        if (phase_items == 0) begin
          case (ph)
            0: n = DEPTH;
            1: n = DEPTH + 2;
            2: n = DEPTH + 1;
            default: n = DEPTH + 3;
          endcase
        end else begin
          n = set_length();
        end
        burst = ($urandom_range(0, 3) == 0);
        tie_heavy = ($urandom_range(0, 3) == 0);
        for (k = 0; k < n; k++)
          push_record(rand_price(tie_heavy), TAG_W'($urandom_range(0, 63)), k == n - 1,
                      burst ? 0 : idle_gap(), 1'b0, '0);
        phase_items += n;
      end
    end

    in_valid <= 1'b0;
    while (sorted_due.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    if (err_count == 0 && sorted_due.size() == 0) begin
      $display("record_exchange_sorter regression: pass");
    end else begin
      $display("record_exchange_sorter regression: fail");
    end
    $finish;
  end

endmodule
